/* sv/rcw_pkg.sv */
// ----------------------------------------------------------------------------
// rcw_pkg
// Shared sizes, status codes and controller/datapath interface types for the
// route chain walker.
// ----------------------------------------------------------------------------
package rcw_pkg;

  // Table depth and city identifier size
  localparam int MAX_ROUTES   = 64;
  localparam int CITY_ID_BITS = 10;

  // Fixed field widths of the word ports
  localparam int CITY_PORT_W = 10;
  localparam int LEG_W       = 16;
  localparam int SUM_W       = 24;
  localparam int HOP_OUT_W   = 8;
  localparam int STATUS_W    = 3;

  // Derived sizes
  localparam int CITY_W = (CITY_ID_BITS < CITY_PORT_W) ? CITY_ID_BITS : CITY_PORT_W;
  localparam int IDX_W  = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int CNT_W  = $clog2(MAX_ROUTES + 1);
  localparam int HOP_W  = (CNT_W + 1 > HOP_OUT_W) ? CNT_W + 1 : HOP_OUT_W;
  localparam int RAM_W  = CITY_W + 2 * LEG_W;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_ORIGIN = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_DEST   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NO_ROUTE  = 3'd5;

  // Controller to datapath commands
  typedef struct packed {
    logic                load;      // latch the accepted input word
    logic                ins_wr;    // store a new route at the fill point
    logic                hop;       // follow the route read from the table
    logic                out_load;  // move the result into the output register
    logic [STATUS_W-1:0] code;      // status of the result being loaded
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_query;
    logic hit;         // current city has a route
    logic dest_known;  // destination is some stored destination
    logic full;
    logic arrived;     // route just read lands on the destination
    logic at_limit;    // this hop is the last one allowed
  } sts_t;

endpackage

/* sv/route_chain_walker_top.sv */
// ----------------------------------------------------------------------------
// route_chain_walker_top
// Route table with insert and hop-by-hop query walk; sequencer plus datapath.
// ----------------------------------------------------------------------------
// Sequence: an insert or a failed check goes from the check state straight to
// the finish state; a query walk does one lane compare and one route RAM read
// per hop.
// Throughput: one word at a time; a new word is taken once the previous
// result has moved to the output register.
// Reset: synchronous active low; clears route count and controller state only.
module route_chain_walker_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [rcw_pkg::CITY_PORT_W-1:0]   in_from_city,
  input  logic [rcw_pkg::CITY_PORT_W-1:0]   in_to_city,
  input  logic [rcw_pkg::LEG_W-1:0]         in_leg_distance,
  input  logic [rcw_pkg::LEG_W-1:0]         in_leg_time,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rcw_pkg::STATUS_W-1:0]      out_status,
  output logic [rcw_pkg::SUM_W-1:0]         out_total_distance,
  output logic [rcw_pkg::SUM_W-1:0]         out_total_time,
  output logic [rcw_pkg::HOP_OUT_W-1:0]     out_hop_count
);
  import rcw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rcw_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (in_op),
    .in_from_city      (in_from_city),
    .in_to_city        (in_to_city),
    .in_leg_distance   (in_leg_distance),
    .in_leg_time       (in_leg_time),
    .out_status        (out_status),
    .out_total_distance(out_total_distance),
    .out_total_time    (out_total_time),
    .out_hop_count     (out_hop_count)
  );

endmodule

/* sv/rcw_ram.sv */
// ----------------------------------------------------------------------------
// rcw_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module rcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/rcw_datapath.sv */
// ----------------------------------------------------------------------------
// rcw_datapath
// Origin/destination match lanes, route RAM, walk accumulators and the
// output register.
// ----------------------------------------------------------------------------
module rcw_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rcw_pkg::cmd_t                      cmd,
  output rcw_pkg::sts_t                      sts,
  input  logic                               in_op,
  input  logic [rcw_pkg::CITY_PORT_W-1:0]    in_from_city,
  input  logic [rcw_pkg::CITY_PORT_W-1:0]    in_to_city,
  input  logic [rcw_pkg::LEG_W-1:0]          in_leg_distance,
  input  logic [rcw_pkg::LEG_W-1:0]          in_leg_time,
  output logic [rcw_pkg::STATUS_W-1:0]       out_status,
  output logic [rcw_pkg::SUM_W-1:0]          out_total_distance,
  output logic [rcw_pkg::SUM_W-1:0]          out_total_time,
  output logic [rcw_pkg::HOP_OUT_W-1:0]      out_hop_count
);
  import rcw_pkg::*;

  // Latched input word and walk state
  logic              op_r;
  logic [CITY_W-1:0] cur_r, cur_nxt;
  logic [CITY_W-1:0] to_r;
  logic [LEG_W-1:0]  dist_r;
  logic [LEG_W-1:0]  time_r;
  logic [SUM_W-1:0]  sd_r, sd_nxt;
  logic [SUM_W-1:0]  st_r, st_nxt;
  logic [HOP_W-1:0]  hops_r, hops_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  // Match lanes, one register per table entry
  logic [CITY_W-1:0] origin_lane_r [MAX_ROUTES];
  logic [CITY_W-1:0] dest_lane_r   [MAX_ROUTES];

  // Output register
  logic [STATUS_W-1:0]  ost_r;
  logic [SUM_W-1:0]     osd_r;
  logic [SUM_W-1:0]     ost_time_r;
  logic [HOP_OUT_W-1:0] ohop_r;

  logic [IDX_W-1:0] hit_idx;
  logic             hit_any;
  logic             dest_any;
  logic [IDX_W-1:0] ram_addr;
  logic [RAM_W-1:0] ram_wdata;
  logic [RAM_W-1:0] ram_rdata;
  logic [CITY_W-1:0] rd_dest;
  logic [LEG_W-1:0]  rd_dist;
  logic [LEG_W-1:0]  rd_time;
  logic [SUM_W:0]    sd_sum;
  logic [SUM_W:0]    st_sum;
  logic [HOP_OUT_W-1:0] hop_sat;

  // Parallel compare of current city and destination against valid lanes
  always_comb begin
    hit_idx  = '0;
    hit_any  = 1'b0;
    dest_any = 1'b0;
    for (int i = 0; i < MAX_ROUTES; i++) begin
      if (CNT_W'(i) < count_r) begin
        if (origin_lane_r[i] == cur_r) begin
          hit_any = 1'b1;
          hit_idx = hit_idx | IDX_W'(i);
        end
        if (dest_lane_r[i] == to_r) begin
          dest_any = 1'b1;
        end
      end
    end
  end

  // Route RAM: insert writes at the fill point, lookups read the hit entry
  assign ram_addr  = cmd.ins_wr ? count_r[IDX_W-1:0] : hit_idx;
  assign ram_wdata = {to_r, dist_r, time_r};

  rcw_ram #(
    .WIDTH(RAM_W),
    .DEPTH(MAX_ROUTES)
  ) u_route_ram (
    .clk  (clk),
    .we   (cmd.ins_wr),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign rd_dest = ram_rdata[RAM_W-1 -: CITY_W];
  assign rd_dist = ram_rdata[2*LEG_W-1 -: LEG_W];
  assign rd_time = ram_rdata[LEG_W-1:0];

  // Saturating sums
  assign sd_sum = {1'b0, sd_r} + {{(SUM_W + 1 - LEG_W){1'b0}}, rd_dist};
  assign st_sum = {1'b0, st_r} + {{(SUM_W + 1 - LEG_W){1'b0}}, rd_time};

  // Walk state next values
  always_comb begin
    cur_nxt   = cur_r;
    sd_nxt    = sd_r;
    st_nxt    = st_r;
    hops_nxt  = hops_r;
    count_nxt = count_r;
    if (cmd.load) begin
      cur_nxt  = in_from_city[CITY_W-1:0];
      sd_nxt   = '0;
      st_nxt   = '0;
      hops_nxt = '0;
    end else if (cmd.hop) begin
      cur_nxt  = rd_dest;
      sd_nxt   = sd_sum[SUM_W] ? {SUM_W{1'b1}} : sd_sum[SUM_W-1:0];
      st_nxt   = st_sum[SUM_W] ? {SUM_W{1'b1}} : st_sum[SUM_W-1:0];
      hops_nxt = hops_r + HOP_W'(1);
    end
    if (cmd.ins_wr) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  // Route count is the only control state here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    sd_r   <= sd_nxt;
    st_r   <= st_nxt;
    hops_r <= hops_nxt;
    if (cmd.load) begin
      op_r   <= in_op;
      to_r   <= in_to_city[CITY_W-1:0];
      dist_r <= in_leg_distance;
      time_r <= in_leg_time;
    end
  end

  // Lane write on insert (origin is the latched current city)
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ROUTES; i++) begin
      if (cmd.ins_wr && count_r == CNT_W'(i)) begin
        origin_lane_r[i] <= cur_r;
        dest_lane_r[i]   <= to_r;
      end
    end
  end

  // Output register; failed words report zero sums and hop count
  assign hop_sat = (hops_r > HOP_W'({HOP_OUT_W{1'b1}})) ? {HOP_OUT_W{1'b1}}
                                                      : hops_r[HOP_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ost_r <= cmd.code;
      if (cmd.code == ST_OK) begin
        osd_r      <= sd_r;
        ost_time_r <= st_r;
        ohop_r     <= hop_sat;
      end else begin
        osd_r      <= '0;
        ost_time_r <= '0;
        ohop_r     <= '0;
      end
    end
  end

  assign out_status         = ost_r;
  assign out_total_distance = osd_r;
  assign out_total_time     = ost_time_r;
  assign out_hop_count      = ohop_r;

  // Status to the controller
  assign sts.is_query   = op_r;
  assign sts.hit        = hit_any;
  assign sts.dest_known = dest_any;
  assign sts.full       = (count_r == CNT_W'(MAX_ROUTES));
  assign sts.arrived    = (rd_dest == to_r);
  assign sts.at_limit   = (hops_r == {{(HOP_W - CNT_W){1'b0}}, count_r} << 1);

endmodule

/* sv/rcw_ctrl.sv */
// ----------------------------------------------------------------------------
// rcw_ctrl
// Sequencer for insert and query words: check, walk, then hand the result
// to the output register.
// ----------------------------------------------------------------------------
module rcw_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  rcw_pkg::sts_t sts,
  output rcw_pkg::cmd_t cmd
);
  import rcw_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DATA  = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [STATUS_W-1:0] code_r, code_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    code_nxt     = code_r;
    cmd.load     = 1'b0;
    cmd.ins_wr   = 1'b0;
    cmd.hop      = 1'b0;
    cmd.out_load = 1'b0;
    cmd.code     = code_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.is_query) begin
          state_nxt = S_FIN;
          if (sts.hit) begin
            code_nxt = ST_DUP;
          end else if (sts.full) begin
            code_nxt = ST_FULL;
          end else begin
            cmd.ins_wr = 1'b1;
            code_nxt   = ST_OK;
          end
        end else if (!sts.hit) begin
          code_nxt  = ST_NO_ORIGIN;
          state_nxt = S_FIN;
        end else if (!sts.dest_known) begin
          code_nxt  = ST_NO_DEST;
          state_nxt = S_FIN;
        end else begin
          // first lookup already issued to the route RAM
          state_nxt = S_DATA;
        end
      end
      S_DATA: begin
        cmd.hop = 1'b1;
        if (sts.arrived) begin
          code_nxt  = ST_OK;
          state_nxt = S_FIN;
        end else if (sts.at_limit) begin
          code_nxt  = ST_NO_ROUTE;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!sts.hit) begin
          code_nxt  = ST_NO_ROUTE;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_DATA;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, cleared when the word is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      code_r      <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* verif/route_chain_walker_top_test.sv */
// ----------------------------------------------------------------------------
// route_chain_walker_top_test
// Self-checking bench for the route chain walker. A directed opening covers
// empty-table queries, duplicates, loops, dead ends and the hop limit. Then
// a random mix of inserts and queries builds chains and cycles, fills the
// table and walks it. Every result word is compared against a trip ledger
// that mirrors the route table. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module route_chain_walker_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rcw_pkg::*;

  localparam int             RANDOM_WORDS = 1532;
  localparam int             CYCLE_LIMIT  = 2_000_000;
  localparam int             DRAIN_CYCLES = 300;
  localparam int             REPORT_MAX   = 10;
  localparam longint unsigned SUM_LIMIT   = (64'd1 << SUM_W) - 1;
  localparam int             HOP_LIMIT    = (1 << HOP_OUT_W) - 1;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } route_op_e;

  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic [SUM_W-1:0]     distance;
    logic [SUM_W-1:0]     duration;
    logic [HOP_OUT_W-1:0] hops;
  } trip_result_t;

  // Mirror of the route table plus the queue of trip results still owed
  class trip_ledger;
    logic [CITY_W-1:0] origin_tab[MAX_ROUTES];
    logic [CITY_W-1:0] dest_tab[MAX_ROUTES];
    logic [LEG_W-1:0]  dist_tab[MAX_ROUTES];
    logic [LEG_W-1:0]  time_tab[MAX_ROUTES];
    int                routes;
    int                faults;
    trip_result_t      awaited[$];

    function new();
      routes = 0;
      faults = 0;
    endfunction

    // index of the route leaving city, -1 if none
    function int route_of(logic [CITY_W-1:0] city);
      for (int i = 0; i < routes; i++) begin
        if (origin_tab[i] == city) return i;
      end
      return -1;
    endfunction

    function bit is_destination(logic [CITY_W-1:0] city);
      for (int i = 0; i < routes; i++) begin
        if (dest_tab[i] == city) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void report(string msg);
      faults++;
      if (faults <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
    endfunction

    // Work out the result of an accepted word and update the table
    function void log_request(route_op_e op, logic [CITY_W-1:0] src,
                              logic [CITY_W-1:0] dst, logic [LEG_W-1:0] leg_dist,
                              logic [LEG_W-1:0] leg_time);
      trip_result_t      res;
      logic [CITY_W-1:0] cur;
      longint unsigned   sum_d;
      longint unsigned   sum_t;
      int                k;
      int                limit;
      int                hops;
      bit                arrived;
      res.status   = ST_OK;
      res.distance = '0;
      res.duration = '0;
      res.hops     = '0;
      if (op == OP_INSERT) begin
        if (route_of(src) >= 0) begin
          res.status = ST_DUP;
        end else if (routes >= MAX_ROUTES) begin
          res.status = ST_FULL;
        end else begin
          origin_tab[routes] = src;
          dest_tab[routes]   = dst;
          dist_tab[routes]   = leg_dist;
          time_tab[routes]   = leg_time;
          routes++;
        end
      end else if (route_of(src) < 0) begin
        res.status = ST_NO_ORIGIN;
      end else if (!is_destination(dst)) begin
        res.status = ST_NO_DEST;
      end else begin
        // walk at least one hop, at most 2*routes+1
        cur     = src;
        limit   = 2 * routes + 1;
        sum_d   = 0;
        sum_t   = 0;
        hops    = 0;
        arrived = 1'b0;
        for (int n = 0; n < limit && !arrived; n++) begin
          k = route_of(cur);
          if (k < 0) break;
          sum_d += dist_tab[k];
          if (sum_d > SUM_LIMIT) sum_d = SUM_LIMIT;
          sum_t += time_tab[k];
          if (sum_t > SUM_LIMIT) sum_t = SUM_LIMIT;
          if (hops < HOP_LIMIT) hops++;
          cur     = dest_tab[k];
          arrived = (cur == dst);
        end
        if (arrived) begin
          res.distance = sum_d[SUM_W-1:0];
          res.duration = sum_t[SUM_W-1:0];
          res.hops     = hops[HOP_OUT_W-1:0];
        end else begin
          res.status = ST_NO_ROUTE;
        end
      end
      awaited.push_back(res);
    endfunction

    // Compare one result word with the oldest owed result
    function void check_result(logic [STATUS_W-1:0] status, logic [SUM_W-1:0] distance,
                               logic [SUM_W-1:0] duration, logic [HOP_OUT_W-1:0] hops);
      trip_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result word with nothing owed: status %0d dist %0d time %0d hops %0d",
                         status, distance, duration, hops));
        return;
      end
      want = awaited.pop_front();
      if (status !== want.status || distance !== want.distance ||
          duration !== want.duration || hops !== want.hops) begin
        report($sformatf({"mismatch: status %0d/%0d dist %0d/%0d time %0d/%0d",
                          " hops %0d/%0d (expected/actual)"},
                         want.status, status, want.distance, distance,
                         want.duration, duration, want.hops, hops));
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_op = 1'b0;
  logic [CITY_PORT_W-1:0] in_from_city = '0;
  logic [CITY_PORT_W-1:0] in_to_city = '0;
  logic [LEG_W-1:0]     in_leg_distance = '0;
  logic [LEG_W-1:0]     in_leg_time = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [SUM_W-1:0]     out_total_distance;
  logic [SUM_W-1:0]     out_total_time;
  logic [HOP_OUT_W-1:0] out_hop_count;

  trip_ledger ledger = new();
  bit         calm = 1'b0;
  int         stall_left = 0;
  int         cycle_count = 0;

  route_chain_walker_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_from_city       (in_from_city),
    .in_to_city         (in_to_city),
    .in_leg_distance    (in_leg_distance),
    .in_leg_time        (in_leg_time),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_total_distance (out_total_distance),
    .out_total_time     (out_total_time),
    .out_hop_count      (out_hop_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then long; none in calm stretches
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one word; returns once it is accepted
  task automatic send_word(route_op_e op, logic [CITY_PORT_W-1:0] src,
                           logic [CITY_PORT_W-1:0] dst, logic [LEG_W-1:0] leg_d,
                           logic [LEG_W-1:0] leg_t);
    int gap;
    gap = idle_span();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_from_city    <= src;
    in_to_city      <= dst;
    in_leg_distance <= leg_d;
    in_leg_time     <= leg_t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ledger.log_request(op, src, dst, leg_d, leg_t);
  endtask

  // Result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 30) stall_left = idle_span();
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      ledger.check_result(out_status, out_total_distance, out_total_time, out_hop_count);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** route_chain_walker_top: FAILED **");
      $finish;
    end
  end

  // Stimulus
  initial begin
    logic [CITY_PORT_W-1:0] src;
    logic [CITY_PORT_W-1:0] dst;
    int                     r;
    int                     k;
    int                     steps;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening
    send_word(OP_QUERY,  10'd5,    10'd7,    16'hFFFF, 16'hFFFF); // empty table
    send_word(OP_INSERT, 10'd0,    10'd1023, 16'hFFFF, 16'hFFFF);
    send_word(OP_INSERT, 10'd1023, 10'd0,    16'h0000, 16'h0000); // two-city loop
    send_word(OP_INSERT, 10'd0,    10'd500,  16'h1234, 16'h4321); // duplicate origin
    send_word(OP_QUERY,  10'd0,    10'd1023, 16'h0000, 16'h0000);
    send_word(OP_QUERY,  10'd0,    10'd0,    16'hA5A5, 16'h5A5A); // round trip to self
    send_word(OP_QUERY,  10'd1023, 10'd5,    16'h0000, 16'hFFFF); // unknown destination
    send_word(OP_QUERY,  10'd12,   10'd0,    16'hFFFF, 16'h0000); // unknown origin
    send_word(OP_INSERT, 10'h155,  10'h2AA,  16'hAAAA, 16'h5555); // 0x2AA is a dead end
    send_word(OP_INSERT, 10'd500,  10'h155,  16'h5555, 16'hAAAA);
    send_word(OP_QUERY,  10'd500,  10'h2AA,  16'h0000, 16'h0000); // two hops
    send_word(OP_QUERY,  10'h155,  10'd0,    16'h0000, 16'h0000); // dead end
    send_word(OP_QUERY,  10'd0,    10'h2AA,  16'h0000, 16'h0000); // loop, hop limit
    send_word(OP_INSERT, 10'd1023, 10'd3,    16'h0001, 16'h0001); // duplicate origin
    send_word(OP_INSERT, 10'd77,   10'd77,   16'h0001, 16'h0002); // self loop
    send_word(OP_QUERY,  10'd77,   10'd77,   16'h0000, 16'h0000); // one hop home
    send_word(OP_QUERY,  10'd77,   10'h2AA,  16'h0000, 16'h0000); // self loop, hop limit
    send_word(OP_QUERY,  10'd500,  10'd500,  16'h0000, 16'h0000); // 500 is no destination

    // Random part: grow chains and cycles, fill the table, then keep walking it
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      calm = ((i / 128) % 5 == 4);
      r = $urandom_range(0, 99);
      if (r < ((ledger.routes < MAX_ROUTES) ? 14 : 6)) begin
        // origin: mostly a chain end or a fresh city, sometimes a repeat
        r = $urandom_range(0, 99);
        if (r < 10 && ledger.routes > 0) begin
          src = ledger.origin_tab[$urandom_range(0, ledger.routes - 1)];
        end else if (r < 55 && ledger.routes > 0) begin
          src = ledger.dest_tab[$urandom_range(0, ledger.routes - 1)];
          if (ledger.route_of(src) >= 0) src = CITY_PORT_W'($urandom_range(0, 1023));
        end else begin
          src = CITY_PORT_W'($urandom_range(0, 1023));
        end
        // destination: link into the existing graph or open a new end
        r = $urandom_range(0, 99);
        if (r < 50 && ledger.routes > 0)
          dst = ledger.origin_tab[$urandom_range(0, ledger.routes - 1)];
        else if (r < 70 && ledger.routes > 0)
          dst = ledger.dest_tab[$urandom_range(0, ledger.routes - 1)];
        else
          dst = CITY_PORT_W'($urandom_range(0, 1023));
        send_word(OP_INSERT, src, dst, LEG_W'($urandom_range(0, 65535)),
                  LEG_W'($urandom_range(0, 65535)));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 80 && ledger.routes > 0)
          src = ledger.origin_tab[$urandom_range(0, ledger.routes - 1)];
        else if (r < 90 && ledger.routes > 0)
          src = ledger.dest_tab[$urandom_range(0, ledger.routes - 1)];
        else
          src = CITY_PORT_W'($urandom_range(0, 1023));
        // destination: mostly a city a few hops down the path
        r = $urandom_range(0, 99);
        if (r < 60 && ledger.routes > 0) begin
          steps = $urandom_range(1, ledger.routes + 1);
          dst = src;
          repeat (steps) begin
            k = ledger.route_of(dst);
            if (k >= 0) dst = ledger.dest_tab[k];
          end
        end else if (r < 85 && ledger.routes > 0) begin
          dst = ledger.dest_tab[$urandom_range(0, ledger.routes - 1)];
        end else begin
          dst = CITY_PORT_W'($urandom_range(0, 1023));
        end
        send_word(OP_QUERY, src, dst, LEG_W'($urandom_range(0, 65535)),
                  LEG_W'($urandom_range(0, 65535)));
      end
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (ledger.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (ledger.faults == 0 && ledger.awaited.size() == 0) begin
      $display("** route_chain_walker_top: PASSED **");
    end else begin
      $display("** route_chain_walker_top: FAILED **");
    end
    $finish;
  end

endmodule
